FILE: src/dns_query_builder_assert.svh
// assertion macros shared by the dns query builder rtl
// no dependencies; included by files that carry concurrent assertions
`ifndef DNS_QUERY_BUILDER_ASSERT_SVH
`define DNS_QUERY_BUILDER_ASSERT_SVH

// same-cycle implication, held off during reset
`define DQB_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, held off during reset
`define DQB_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: src/dqb_pkg.sv
// types, codes and constants of the dns query builder
// no dependencies; imported by dqb_front, dqb_back and the top level
`timescale 1ns / 1ps
`default_nettype none

package dqb_pkg;

    // default label limit and sizes
    localparam int MAX_LABEL_DEF = 32;
    localparam int CMD_DEPTH     = 2;
    localparam int RES_DEPTH     = 4;
    localparam int CFG_IDX_W     = 8;
    localparam int HDR_BYTES     = 12;
    localparam int TAIL_BYTES    = 5;

    localparam logic [7:0]  DOT_CHAR = 8'd46;
    localparam logic [15:0] QDCOUNT  = 16'h0001;

    // config register indexes and reset values
    localparam logic [CFG_IDX_W-1:0] CFG_QUERY_ID     = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HEADER_FLAGS = 8'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_QUERY_TYPE   = 8'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_QUERY_CLASS  = 8'd3;

    localparam logic [15:0] RST_QUERY_ID     = 16'hff00;
    localparam logic [15:0] RST_HEADER_FLAGS = 16'h0100;
    localparam logic [15:0] RST_QUERY_TYPE   = 16'h0001;
    localparam logic [15:0] RST_QUERY_CLASS  = 16'h0001;

    // item kinds
    localparam logic KIND_CHAR = 1'b0;
    localparam logic KIND_END  = 1'b1;

    // command operations from front to back
    localparam logic [1:0] OP_CHAR = 2'd0;
    localparam logic [1:0] OP_DOT  = 2'd1;
    localparam logic [1:0] OP_END  = 2'd2;

    typedef struct packed {
        logic       kind;
        logic [7:0] name_char;
    } t_item;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       last_byte;
        logic       label_overflow;
    } t_res;

    typedef struct packed {
        logic       hdr;
        logic [1:0] op;
        logic [7:0] ch;
    } t_cmd;

    typedef struct packed {
        logic [15:0] query_id;
        logic [15:0] header_flags;
        logic [15:0] query_type;
        logic [15:0] query_class;
    } t_cfg;

endpackage

`default_nettype wire

FILE: src/dqb_ram.sv
// generic single write port ram with registered, enabled read
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

module dqb_ram #(
    parameter int Width = 8,
    parameter int Depth = 32,
    parameter int AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AddrW-1:0] i_waddr,
    input  wire logic [Width-1:0] i_wdata,
    input  wire logic             i_re,
    input  wire logic [AddrW-1:0] i_raddr,
    output logic      [Width-1:0] o_rdata
);

    logic [Width-1:0] r_mem [Depth];
    logic [Width-1:0] r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read, holds while not enabled
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

FILE: src/dqb_fifo.sv
// small register queue, head shown on the output while not empty
// no dependencies; depth must be a power of two
`timescale 1ns / 1ps
`default_nettype none

module dqb_fifo #(
    parameter int Width = 8,
    parameter int Depth = 2
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_push,
    input  wire logic [Width-1:0] i_data,
    output logic                  o_full,
    input  wire logic             i_pop,
    output logic      [Width-1:0] o_data,
    output logic                  o_empty
);

    localparam int PW = $clog2(Depth);

    logic [Width-1:0] r_mem [Depth];
    logic [PW:0]      r_wr, n_wr;
    logic [PW:0]      r_rd, n_rd;
    logic             wr_en;
    logic             rd_en;

    // pointer compare with wrap bit
    assign o_empty = (r_wr == r_rd);
    assign o_full  = (r_wr[PW] != r_rd[PW]) && (r_wr[PW-1:0] == r_rd[PW-1:0]);
    assign wr_en   = i_push && !o_full;
    assign rd_en   = i_pop && !o_empty;
    assign n_wr    = wr_en ? r_wr + 1'b1 : r_wr;
    assign n_rd    = rd_en ? r_rd + 1'b1 : r_rd;
    assign o_data  = r_mem[r_rd[PW-1:0]];

    // pointers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr <= '0;
            r_rd <= '0;
        end else begin
            r_wr <= n_wr;
            r_rd <= n_rd;
        end
    end

    // storage
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[r_wr[PW-1:0]] <= i_data;
        end
    end

endmodule

`default_nettype wire

FILE: src/dqb_front.sv
// front end: accepts name items, tags the first one of a name for a header
// and classifies each as character, dot or end; depends on dqb_pkg
`timescale 1ns / 1ps
`default_nettype none

module dqb_front (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_push,
    input  wire dqb_pkg::t_item i_in,
    output logic                o_full,
    output logic                o_cmd_push,
    output dqb_pkg::t_cmd       o_cmd,
    input  wire logic           i_cmd_full
);

    import dqb_pkg::*;

    logic r_hdr_done, n_hdr_done;
    logic accept;

    assign o_full     = i_cmd_full;
    assign accept     = i_push && !i_cmd_full;
    assign o_cmd_push = accept;

    // classify the item
    always_comb begin
        o_cmd.hdr = !r_hdr_done;
        o_cmd.ch  = i_in.name_char;
        if (i_in.kind == KIND_END) begin
            o_cmd.op = OP_END;
        end else if (i_in.name_char == DOT_CHAR) begin
            o_cmd.op = OP_DOT;
        end else begin
            o_cmd.op = OP_CHAR;
        end
    end

    // header pending until the end item rearms it
    always_comb begin
        n_hdr_done = r_hdr_done;
        if (accept) begin
            n_hdr_done = (o_cmd.op != OP_END);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hdr_done <= 1'b0;
        end else begin
            r_hdr_done <= n_hdr_done;
        end
    end

endmodule

`default_nettype wire

FILE: src/dqb_back.sv
// back end: runs commands, keeps the label store, emits header, labels
// and trailer bytes into the result queue; depends on dqb_pkg and dqb_ram
`timescale 1ns / 1ps
`default_nettype none

module dqb_back #(
    parameter int MaxLabel = dqb_pkg::MAX_LABEL_DEF
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire dqb_pkg::t_cfg i_cfg,
    input  wire dqb_pkg::t_cmd i_cmd,
    input  wire logic          i_cmd_empty,
    output logic               o_cmd_pop,
    output logic               o_res_push,
    output dqb_pkg::t_res      o_res,
    input  wire logic          i_res_full
);

    import dqb_pkg::*;

    localparam int CW = $clog2(MaxLabel + 1);
    localparam int AW = (MaxLabel > 1) ? $clog2(MaxLabel) : 1;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_HDR   = 3'd1;
    localparam logic [2:0] S_LEN   = 3'd2;
    localparam logic [2:0] S_CHARS = 3'd3;
    localparam logic [2:0] S_TAIL  = 3'd4;

    logic [2:0]    r_state, n_state;
    logic [1:0]    r_op, n_op;
    logic [7:0]    r_ch, n_ch;
    logic [3:0]    r_idx, n_idx;
    logic [CW-1:0] r_count, n_count;
    logic          r_trunc, n_trunc;
    logic [CW-1:0] r_rd, n_rd;
    logic [CW-1:0] r_out, n_out;
    logic          r_dv, n_dv;

    logic          do_store;
    logic [7:0]    st_wdata;
    logic          st_we;
    logic          rd_en;
    logic          push_char;
    logic [7:0]    rd_data;

    // header byte by position
    function automatic logic [7:0] f_hdr_byte(input logic [3:0] idx, input t_cfg cfg);
        logic [7:0] b;
        unique case (idx)
            4'd0:    b = cfg.query_id[15:8];
            4'd1:    b = cfg.query_id[7:0];
            4'd2:    b = cfg.header_flags[15:8];
            4'd3:    b = cfg.header_flags[7:0];
            4'd4:    b = QDCOUNT[15:8];
            4'd5:    b = QDCOUNT[7:0];
            default: b = 8'h00;
        endcase
        return b;
    endfunction

    // trailer byte by position: root, qtype, qclass
    function automatic logic [7:0] f_tail_byte(input logic [3:0] idx, input t_cfg cfg);
        logic [7:0] b;
        unique case (idx)
            4'd1:    b = cfg.query_type[15:8];
            4'd2:    b = cfg.query_type[7:0];
            4'd3:    b = cfg.query_class[15:8];
            4'd4:    b = cfg.query_class[7:0];
            default: b = 8'h00;
        endcase
        return b;
    endfunction

    // label store
    dqb_ram #(
        .Width (8),
        .Depth (MaxLabel),
        .AddrW (AW)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (st_we),
        .i_waddr (r_count[AW-1:0]),
        .i_wdata (st_wdata),
        .i_re    (rd_en),
        .i_raddr (r_rd[AW-1:0]),
        .o_rdata (rd_data)
    );

    assign push_char = (r_state == S_CHARS) && r_dv && !i_res_full;

    // sequencer
    always_comb begin
        n_state    = r_state;
        n_op       = r_op;
        n_ch       = r_ch;
        n_idx      = r_idx;
        n_count    = r_count;
        n_trunc    = r_trunc;
        n_rd       = r_rd;
        n_out      = r_out;
        n_dv       = r_dv;
        o_cmd_pop  = 1'b0;
        o_res_push = 1'b0;
        o_res      = '0;
        do_store   = 1'b0;
        st_wdata   = r_ch;
        st_we      = 1'b0;
        rd_en      = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                if (!i_cmd_empty) begin
                    o_cmd_pop = 1'b1;
                    n_op      = i_cmd.op;
                    n_ch      = i_cmd.ch;
                    if (i_cmd.hdr) begin
                        n_state = S_HDR;
                        n_idx   = '0;
                    end else if (i_cmd.op == OP_CHAR) begin
                        do_store = 1'b1;
                        st_wdata = i_cmd.ch;
                    end else begin
                        n_state = S_LEN;
                    end
                end
            end
            S_HDR: begin
                if (!i_res_full) begin
                    o_res_push     = 1'b1;
                    o_res.out_byte = f_hdr_byte(r_idx, i_cfg);
                    if (r_idx == 4'(HDR_BYTES - 1)) begin
                        if (r_op == OP_CHAR) begin
                            do_store = 1'b1;
                            n_state  = S_IDLE;
                        end else begin
                            n_state = S_LEN;
                        end
                    end else begin
                        n_idx = r_idx + 4'd1;
                    end
                end
            end
            S_LEN: begin
                if (!i_res_full) begin
                    o_res_push           = 1'b1;
                    o_res.out_byte       = 8'(r_count);
                    o_res.label_overflow = r_trunc;
                    if (r_count == '0) begin
                        n_trunc = 1'b0;
                        n_idx   = '0;
                        n_state = (r_op == OP_END) ? S_TAIL : S_IDLE;
                    end else begin
                        n_state = S_CHARS;
                        n_rd    = '0;
                        n_out   = '0;
                        n_dv    = 1'b0;
                    end
                end
            end
            S_CHARS: begin
                // read one entry ahead, hold it while the queue is full
                rd_en = (r_rd != r_count) && (!r_dv || push_char);
                if (rd_en) begin
                    n_rd = r_rd + 1'b1;
                    n_dv = 1'b1;
                end else if (push_char) begin
                    n_dv = 1'b0;
                end
                if (push_char) begin
                    o_res_push     = 1'b1;
                    o_res.out_byte = rd_data;
                    n_out          = r_out + 1'b1;
                    if (r_out + 1'b1 == r_count) begin
                        n_count = '0;
                        n_trunc = 1'b0;
                        n_idx   = '0;
                        n_state = (r_op == OP_END) ? S_TAIL : S_IDLE;
                    end
                end
            end
            S_TAIL: begin
                if (!i_res_full) begin
                    o_res_push      = 1'b1;
                    o_res.out_byte  = f_tail_byte(r_idx, i_cfg);
                    o_res.last_byte = (r_idx == 4'(TAIL_BYTES - 1));
                    if (r_idx == 4'(TAIL_BYTES - 1)) begin
                        n_state = S_IDLE;
                    end else begin
                        n_idx = r_idx + 4'd1;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        // character store, extra characters only set the flag
        if (do_store) begin
            if (r_count < CW'(MaxLabel)) begin
                st_we   = 1'b1;
                n_count = r_count + 1'b1;
            end else begin
                n_trunc = 1'b1;
            end
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_op    <= OP_CHAR;
            r_idx   <= '0;
            r_count <= '0;
            r_trunc <= 1'b0;
            r_rd    <= '0;
            r_out   <= '0;
            r_dv    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_op    <= n_op;
            r_idx   <= n_idx;
            r_count <= n_count;
            r_trunc <= n_trunc;
            r_rd    <= n_rd;
            r_out   <= n_out;
            r_dv    <= n_dv;
        end
    end

    // held character
    always_ff @(posedge i_clk) begin
        r_ch <= n_ch;
    end

endmodule

`default_nettype wire

FILE: src/dns_query_builder.sv
// dns query builder top level: config registers, front end, command queue,
// back end and result queue; depends on dqb_pkg and all dqb_ modules
`timescale 1ns / 1ps
`default_nettype none

// Builds a DNS query packet, one byte per result, from a domain name given one
// character per input item, the end item closing the name. The first item of a
// name brings the 12-byte header; a dot or the end item brings the label's
// length byte and its characters; the end item adds the root byte, QTYPE and
// QCLASS and flags the last byte. Labels keep at most MaxLabel characters; the
// length byte of a clipped label carries label_overflow. The front end takes one
// item per cycle, while the command queue is not full, into a two-entry command
// queue. The back end stores a character, or writes out a header, a label or a
// trailer, and takes the next command only once it is idle again; its label
// store is read one entry per cycle while the result queue is not full. A
// four-entry result queue lets the back end run ahead of pop.
// Config writes are taken every cycle and must only happen while the block is idle.
module dns_query_builder #(
    parameter int MaxLabel = dqb_pkg::MAX_LABEL_DEF
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_push,
    input  wire dqb_pkg::t_item                  i_in,
    output logic                                 o_full,
    output logic                                 o_empty,
    input  wire logic                            i_pop,
    output dqb_pkg::t_res                        o_out,
    input  wire logic                            i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  wire logic [dqb_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  wire logic [15:0]                     i_cfg_data
);

    import dqb_pkg::*;

    `include "dns_query_builder_assert.svh"

    t_cfg  r_cfg, n_cfg;
    t_cmd  cmd_in;
    t_cmd  cmd_out;
    t_res  res_in;
    t_res  res_out;
    logic  cmd_push;
    logic  cmd_full;
    logic  cmd_empty;
    logic  cmd_pop;
    logic  res_push;
    logic  res_full;
    logic  cfg_we;

    // config register file
    assign o_cfg_ready = 1'b1;
    assign cfg_we      = i_cfg_valid && o_cfg_ready;

    always_comb begin
        n_cfg = r_cfg;
        if (cfg_we) begin
            unique case (i_cfg_index)
                CFG_QUERY_ID:     n_cfg.query_id     = i_cfg_data;
                CFG_HEADER_FLAGS: n_cfg.header_flags = i_cfg_data;
                CFG_QUERY_TYPE:   n_cfg.query_type   = i_cfg_data;
                CFG_QUERY_CLASS:  n_cfg.query_class  = i_cfg_data;
                default:          n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.query_id     <= RST_QUERY_ID;
            r_cfg.header_flags <= RST_HEADER_FLAGS;
            r_cfg.query_type   <= RST_QUERY_TYPE;
            r_cfg.query_class  <= RST_QUERY_CLASS;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    // front end
    dqb_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (i_push),
        .i_in       (i_in),
        .o_full     (o_full),
        .o_cmd_push (cmd_push),
        .o_cmd      (cmd_in),
        .i_cmd_full (cmd_full)
    );

    // command queue
    dqb_fifo #(
        .Width ($bits(t_cmd)),
        .Depth (CMD_DEPTH)
    ) u_cmd_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (cmd_push),
        .i_data  (cmd_in),
        .o_full  (cmd_full),
        .i_pop   (cmd_pop),
        .o_data  (cmd_out),
        .o_empty (cmd_empty)
    );

    // back end
    dqb_back #(
        .MaxLabel (MaxLabel)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_cmd       (cmd_out),
        .i_cmd_empty (cmd_empty),
        .o_cmd_pop   (cmd_pop),
        .o_res_push  (res_push),
        .o_res       (res_in),
        .i_res_full  (res_full)
    );

    // result queue
    dqb_fifo #(
        .Width ($bits(t_res)),
        .Depth (RES_DEPTH)
    ) u_res_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (res_push),
        .i_data  (res_in),
        .o_full  (res_full),
        .i_pop   (i_pop),
        .o_data  (res_out),
        .o_empty (o_empty)
    );

    assign o_out = res_out;

    // checks
    `DQB_ASSERT_NOW(a_no_push_full, i_clk, i_rst_n, res_push, !res_full,
        "back end pushed a request into a full result queue")
    `DQB_ASSERT_NOW(a_no_pop_empty, i_clk, i_rst_n, cmd_pop, !cmd_empty,
        "back end popped an empty command queue")
    `DQB_ASSERT_NOW(a_flag_excl, i_clk, i_rst_n, res_push,
        !(res_in.last_byte && res_in.label_overflow),
        "last byte and label overflow set on one request")
    `DQB_ASSERT_NEXT(a_cmd_taken, i_clk, i_rst_n, cmd_push && !cmd_full, !cmd_empty,
        "accepted command did not reach the queue")

endmodule

`default_nettype wire
